// ----- rtl/core/gds_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the gesture debounce block
// no dependencies; used by the interfaces and every module in rtl/core

package gds_pkg;

  // debounce machine states, encoded as the result field machine_state
  typedef enum logic [2:0] {
    ST_NO_HAND   = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_CANDIDATE = 3'd2,
    ST_ACTIVE    = 3'd3,
    ST_RELEASED  = 3'd4
  } state_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CONFIRM_FRAMES = 3'd0,
    REG_CONFIRM_TIME   = 3'd1,
    REG_MAX_GAP        = 3'd2,
    REG_COOLDOWN       = 3'd3,
    REG_MIN_CONF       = 3'd4
  } cfg_reg_t;

  localparam int unsigned IdW    = 3;
  localparam int unsigned ConfW  = 16;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [IdW-1:0]    ID_UNKNOWN = 3'd0;
  localparam logic [IdW-1:0]    ID_MAX     = 3'd4;
  localparam logic [CountW-1:0] COUNT_MAX  = 16'hffff;

  // register reset values
  localparam logic [7:0]       RST_CONFIRM_FRAMES = 8'd5;
  localparam logic [31:0]      RST_CONFIRM_TIME   = 32'd150000;
  localparam logic [31:0]      RST_MAX_GAP        = 32'd250000;
  localparam logic [31:0]      RST_COOLDOWN       = 32'd300000;
  localparam logic [ConfW-1:0] RST_MIN_CONF       = 16'd49152;  // 0.75 in Q0.16

  typedef struct packed {
    logic [7:0]       confirm_frames;
    logic [31:0]      confirm_time_us;
    logic [31:0]      max_gap_us;
    logic [31:0]      cooldown_us;
    logic [ConfW-1:0] min_active_confidence;
  } cfg_t;

  typedef struct packed {
    logic             hand_present;
    logic [IdW-1:0]   gesture_id;
    logic [ConfW-1:0] confidence;
    logic [TimeW-1:0] now_us;
  } frame_t;

  typedef struct packed {
    state_t            machine_state;
    logic [IdW-1:0]    observed_id;
    logic [ConfW-1:0]  observed_confidence;
    logic [IdW-1:0]    confirmed_id;
    logic [CountW-1:0] candidate_count;
  } result_t;

endpackage

// ----- rtl/core/gds_frame_if.sv -----
`timescale 1ns / 1ps
// frame channel: valid/ready handshake with one camera frame observation
// depends on gds_pkg for field widths

interface gds_frame_if;
  logic                      valid;
  logic                      ready;
  logic                      hand_present;
  logic [gds_pkg::IdW-1:0]   gesture_id;
  logic [gds_pkg::ConfW-1:0] confidence;
  logic [gds_pkg::TimeW-1:0] now_us;

  modport source (output valid, hand_present, gesture_id, confidence, now_us, input ready);
  modport sink   (input valid, hand_present, gesture_id, confidence, now_us, output ready);
endinterface

// ----- rtl/core/gds_result_if.sv -----
`timescale 1ns / 1ps
// result channel: valid/ready handshake with one debounce result per frame
// depends on gds_pkg for field widths

interface gds_result_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 machine_state;
  logic [gds_pkg::IdW-1:0]    observed_id;
  logic [gds_pkg::ConfW-1:0]  observed_confidence;
  logic [gds_pkg::IdW-1:0]    confirmed_id;
  logic [gds_pkg::CountW-1:0] candidate_count;

  modport source (output valid, machine_state, observed_id, observed_confidence,
                  confirmed_id, candidate_count, input ready);
  modport sink   (input valid, machine_state, observed_id, observed_confidence,
                  confirmed_id, candidate_count, output ready);
endinterface

// ----- rtl/core/gds_cfg_if.sv -----
`timescale 1ns / 1ps
// configuration write channel: register index and write data
// depends on gds_pkg for field widths

interface gds_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gds_pkg::CfgIdxW-1:0]  index;
  logic [gds_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gds_cfg_regs.sv -----
`timescale 1ns / 1ps
// configuration register file for the gesture debounce block
// depends on gds_pkg and gds_cfg_if

module gds_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  gds_cfg_if.sink        cfg,
  output gds_pkg::cfg_t  cfg_regs
);

  gds_pkg::cfg_t regs;

  // writes are always taken
  assign cfg.ready = 1'b1;
  assign cfg_regs  = regs;

  // register write decode, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.confirm_frames        <= gds_pkg::RST_CONFIRM_FRAMES;
      regs.confirm_time_us       <= gds_pkg::RST_CONFIRM_TIME;
      regs.max_gap_us            <= gds_pkg::RST_MAX_GAP;
      regs.cooldown_us           <= gds_pkg::RST_COOLDOWN;
      regs.min_active_confidence <= gds_pkg::RST_MIN_CONF;
    end else if (cfg.valid) begin
      unique case (gds_pkg::cfg_reg_t'(cfg.index))
        gds_pkg::REG_CONFIRM_FRAMES: regs.confirm_frames <= cfg.data[7:0];
        gds_pkg::REG_CONFIRM_TIME:   regs.confirm_time_us <= cfg.data;
        gds_pkg::REG_MAX_GAP:        regs.max_gap_us <= cfg.data;
        gds_pkg::REG_COOLDOWN:       regs.cooldown_us <= cfg.data;
        gds_pkg::REG_MIN_CONF:
          regs.min_active_confidence <= cfg.data[gds_pkg::ConfW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/gds_core.sv -----
`timescale 1ns / 1ps
// debounce state registers and the combinational next-state logic
// depends on gds_pkg

module gds_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  gds_pkg::cfg_t    cfg,
  input  gds_pkg::frame_t  frame,
  output gds_pkg::result_t result
);

  // state registers
  gds_pkg::state_t                mode, mode_next;
  logic [gds_pkg::IdW-1:0]        active_gesture, active_gesture_next;
  logic [gds_pkg::IdW-1:0]        candidate_gesture, candidate_gesture_next;
  logic [gds_pkg::CountW-1:0]     candidate_frames, candidate_frames_next;
  logic [gds_pkg::TimeW-1:0]      candidate_start_time, candidate_start_time_next;
  logic [gds_pkg::TimeW-1:0]      cooldown_end_time, cooldown_end_time_next;
  logic [gds_pkg::TimeW-1:0]      last_frame_time;

  logic [gds_pkg::IdW-1:0]   id;
  logic [gds_pkg::TimeW-1:0] now;
  logic [gds_pkg::TimeW-1:0] frame_delta;
  logic                      gap;
  logic [gds_pkg::TimeW:0]   end_sum;
  logic [gds_pkg::TimeW-1:0] release_end;
  logic                      recognized;
  logic                      gap_release;
  gds_pkg::state_t           mode_g;
  logic [gds_pkg::TimeW-1:0] cooldown_end_g;
  logic                      in_cooldown;
  logic [gds_pkg::TimeW-1:0] since_start;
  logic                      time_met_same;
  logic                      time_met_new;
  logic [gds_pkg::CountW-1:0] frames_inc;

  // ids beyond the last gesture read as unknown
  assign id  = (frame.gesture_id > gds_pkg::ID_MAX) ? gds_pkg::ID_UNKNOWN : frame.gesture_id;
  assign now = frame.now_us;

  // frame gap or timestamp going backward; none before the first frame
  assign frame_delta = now - last_frame_time;
  assign gap = (last_frame_time != '0) &&
               ((now < last_frame_time) ||
                (frame_delta > {{(gds_pkg::TimeW-32){1'b0}}, cfg.max_gap_us}));

  // cooldown end, saturating
  assign end_sum     = {1'b0, now} + {{(gds_pkg::TimeW-31){1'b0}}, cfg.cooldown_us};
  assign release_end = end_sum[gds_pkg::TimeW] ? '1 : end_sum[gds_pkg::TimeW-1:0];

  assign recognized = frame.hand_present && (id != gds_pkg::ID_UNKNOWN) &&
                      (frame.confidence >= cfg.min_active_confidence);

  // state as seen after a possible gap release
  assign gap_release    = gap && ((mode == gds_pkg::ST_ACTIVE) ||
                                  (mode == gds_pkg::ST_CANDIDATE));
  assign mode_g         = gap_release ? gds_pkg::ST_RELEASED : mode;
  assign cooldown_end_g = gap_release ? release_end : cooldown_end_time;
  assign in_cooldown    = (mode_g == gds_pkg::ST_RELEASED) && (now < cooldown_end_g);

  // confirm time check, elapsed clamps at zero before the start stamp
  assign since_start   = now - candidate_start_time;
  assign time_met_same = (now >= candidate_start_time) ?
                         (since_start >= {{(gds_pkg::TimeW-32){1'b0}}, cfg.confirm_time_us}) :
                         (cfg.confirm_time_us == '0);
  assign time_met_new  = (cfg.confirm_time_us == '0);
  assign frames_inc    = (candidate_frames == gds_pkg::COUNT_MAX) ?
                         candidate_frames :
                         candidate_frames + {{(gds_pkg::CountW-1){1'b0}}, 1'b1};

  // next state
  always_comb begin
    mode_next                 = mode_g;
    active_gesture_next       = gap_release ? '0 : active_gesture;
    candidate_gesture_next    = gap_release ? '0 : candidate_gesture;
    candidate_frames_next     = gap_release ? '0 : candidate_frames;
    candidate_start_time_next = gap_release ? '0 : candidate_start_time;
    cooldown_end_time_next    = cooldown_end_g;
    if (!recognized) begin
      if ((mode_g == gds_pkg::ST_ACTIVE) || (mode_g == gds_pkg::ST_CANDIDATE)) begin
        mode_next                 = gds_pkg::ST_RELEASED;
        candidate_gesture_next    = '0;
        candidate_frames_next     = '0;
        candidate_start_time_next = '0;
        cooldown_end_time_next    = release_end;
      end else if (!in_cooldown) begin
        mode_next = frame.hand_present ? gds_pkg::ST_UNKNOWN : gds_pkg::ST_NO_HAND;
      end
      active_gesture_next = '0;
    end else if (in_cooldown) begin
      active_gesture_next = '0;
    end else if (mode_g == gds_pkg::ST_ACTIVE) begin
      // a different gesture while active releases it
      if (id != active_gesture) begin
        mode_next                 = gds_pkg::ST_RELEASED;
        active_gesture_next       = '0;
        candidate_gesture_next    = '0;
        candidate_frames_next     = '0;
        candidate_start_time_next = '0;
        cooldown_end_time_next    = release_end;
      end
    end else begin
      mode_next = gds_pkg::ST_CANDIDATE;
      if (id != candidate_gesture_next) begin
        candidate_gesture_next    = id;
        candidate_frames_next     = {{(gds_pkg::CountW-1){1'b0}}, 1'b1};
        candidate_start_time_next = now;
        if (({{(gds_pkg::CountW-8){1'b0}}, cfg.confirm_frames} <=
             {{(gds_pkg::CountW-1){1'b0}}, 1'b1}) && time_met_new) begin
          mode_next           = gds_pkg::ST_ACTIVE;
          active_gesture_next = id;
        end
      end else begin
        candidate_frames_next = frames_inc;
        if ((frames_inc >= {{(gds_pkg::CountW-8){1'b0}}, cfg.confirm_frames}) &&
            time_met_same) begin
          mode_next           = gds_pkg::ST_ACTIVE;
          active_gesture_next = id;
        end
      end
    end
  end

  // result fields
  always_comb begin
    result.machine_state       = mode_next;
    result.observed_id         = frame.hand_present ? id : gds_pkg::ID_UNKNOWN;
    result.observed_confidence = frame.hand_present ? frame.confidence : '0;
    result.confirmed_id        = active_gesture_next;
    result.candidate_count     = candidate_frames_next;
  end

  // state update, one frame per step
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                 <= gds_pkg::ST_NO_HAND;
      active_gesture       <= '0;
      candidate_gesture    <= '0;
      candidate_frames     <= '0;
      candidate_start_time <= '0;
      cooldown_end_time    <= '0;
      last_frame_time      <= '0;
    end else if (step) begin
      mode                 <= mode_next;
      active_gesture       <= active_gesture_next;
      candidate_gesture    <= candidate_gesture_next;
      candidate_frames     <= candidate_frames_next;
      candidate_start_time <= candidate_start_time_next;
      cooldown_end_time    <= cooldown_end_time_next;
      last_frame_time      <= now;
    end
  end

endmodule

// ----- rtl/core/gesture_debounce_state_machine.sv -----
`timescale 1ns / 1ps
// Gesture debounce state machine: takes one frame request per clock while the result side
// is not stalled, and returns one result per frame. A frame is captured in an input
// register, passes once through the next-state logic that updates the five-state debounce
// machine, and lands in a result register; the state registers are updated together with
// the result register, so throughput is one frame per cycle while the result side is not
// stalled. Configuration writes take effect at once and are to be made only while no
// frame is in flight. Depends on gds_pkg, the channel interfaces, gds_cfg_regs and gds_core.

module gesture_debounce_state_machine (
  input  logic          clk,
  input  logic          rst,
  gds_frame_if.sink     frame,
  gds_result_if.source  result,
  gds_cfg_if.sink       cfg
);

  gds_pkg::cfg_t    cfg_regs;
  gds_pkg::frame_t  frame_q;
  logic             frame_valid;
  gds_pkg::result_t step_result;
  gds_pkg::result_t result_q;
  logic             result_valid;
  logic             advance;

  gds_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_regs (cfg_regs)
  );

  gds_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg_regs),
    .frame  (frame_q),
    .result (step_result)
  );

  // frame moves on when the result register is free or being drained
  assign advance     = frame_valid && (!result_valid || result.ready);
  assign frame.ready = !frame_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame.ready) begin
      frame_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      frame_q.hand_present <= frame.hand_present;
      frame_q.gesture_id   <= frame.gesture_id;
      frame_q.confidence   <= frame.confidence;
      frame_q.now_us       <= frame.now_us;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign result.valid               = result_valid;
  assign result.machine_state       = result_q.machine_state;
  assign result.observed_id         = result_q.observed_id;
  assign result.observed_confidence = result_q.observed_confidence;
  assign result.confirmed_id        = result_q.confirmed_id;
  assign result.candidate_count     = result_q.candidate_count;

  // a held frame is never dropped while the result side stalls
  assert property (@(posedge clk) disable iff (rst)
    frame_valid && !advance |=> frame_valid)
    else $error("held frame lost");

  // a confirmed id is shown exactly in the active state
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result_q.confirmed_id != '0) ==
                      (result_q.machine_state == gds_pkg::ST_ACTIVE)))
    else $error("confirmed id does not match active state");

  // no hand state only comes from a frame without a hand
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_q.machine_state == gds_pkg::ST_NO_HAND) |->
      (result_q.observed_id == '0) && (result_q.observed_confidence == '0))
    else $error("no hand state with observed data");

  // a candidate has counted at least one frame
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_q.machine_state == gds_pkg::ST_CANDIDATE) |->
      (result_q.candidate_count != '0))
    else $error("candidate state with zero count");

  // released state carries no candidate and no confirmed gesture
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_q.machine_state == gds_pkg::ST_RELEASED) |->
      (result_q.candidate_count == '0) && (result_q.confirmed_id == '0))
    else $error("released state with leftover gesture");

endmodule
